// ----- hw/rtl/afb_pkg.sv -----
package afb_pkg;

  localparam int unsigned FrameBytes = 32;
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  localparam int unsigned CrcAt      = 14;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcOnes = 32'hFFFFFFFF;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameBytes - 1);

  localparam logic [1:0] RegMagic   = 2'd0;
  localparam logic [1:0] RegVersion = 2'd1;
  localparam logic [1:0] RegAckType = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StCrc,
    StEmit
  } state_e;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  ack_type;
  } cfg_t;

  typedef struct packed {
    logic [31:0] seq;
    logic        status;
    logic [31:0] wtime;
    logic [31:0] ptime;
  } fields_t;

  typedef struct packed {
    logic       init;
    logic       step;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

// ----- hw/rtl/afb_crc_unit.sv -----
module afb_crc_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  afb_pkg::crc_ctrl_t ctrl_i,
  output logic [31:0]        crc_o
);

  logic [31:0] crc_q, crc_d, upd;

  // One byte of reflected CRC-32, bit by bit.
  always_comb begin
    upd = crc_q ^ {24'd0, ctrl_i.data};
    for (int k = 0; k < 8; k++) begin
      if (upd[0]) begin
        upd = (upd >> 1) ^ afb_pkg::CrcPoly;
      end else begin
        upd = upd >> 1;
      end
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = afb_pkg::CrcOnes;
    end else if (ctrl_i.step) begin
      crc_d = upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= afb_pkg::CrcOnes;
    end else begin
      crc_q <= crc_d;
    end
  end

  // Apply the final xor on the way out.
  assign crc_o = crc_q ^ afb_pkg::CrcOnes;

endmodule

// ----- hw/rtl/afb_frame_mux.sv -----
module afb_frame_mux (
  input  logic [afb_pkg::IdxW-1:0] offset_i,
  input  afb_pkg::cfg_t            cfg_i,
  input  afb_pkg::fields_t         fields_i,
  input  logic [31:0]              crc_i,
  output logic [7:0]               byte_o
);

  logic [15:0] len;
  assign len = 16'(afb_pkg::FrameBytes);

  always_comb begin
    case (offset_i)
      afb_pkg::IdxW'(0):  byte_o = cfg_i.magic[7:0];
      afb_pkg::IdxW'(1):  byte_o = cfg_i.magic[15:8];
      afb_pkg::IdxW'(2):  byte_o = cfg_i.version;
      afb_pkg::IdxW'(3):  byte_o = cfg_i.ack_type;
      afb_pkg::IdxW'(4):  byte_o = len[7:0];
      afb_pkg::IdxW'(5):  byte_o = len[15:8];
      afb_pkg::IdxW'(14): byte_o = crc_i[7:0];
      afb_pkg::IdxW'(15): byte_o = crc_i[15:8];
      afb_pkg::IdxW'(16): byte_o = crc_i[23:16];
      afb_pkg::IdxW'(17): byte_o = crc_i[31:24];
      afb_pkg::IdxW'(18): byte_o = fields_i.seq[7:0];
      afb_pkg::IdxW'(19): byte_o = fields_i.seq[15:8];
      afb_pkg::IdxW'(20): byte_o = fields_i.seq[23:16];
      afb_pkg::IdxW'(21): byte_o = fields_i.seq[31:24];
      afb_pkg::IdxW'(22): byte_o = {7'd0, fields_i.status};
      afb_pkg::IdxW'(23): byte_o = fields_i.wtime[7:0];
      afb_pkg::IdxW'(24): byte_o = fields_i.wtime[15:8];
      afb_pkg::IdxW'(25): byte_o = fields_i.wtime[23:16];
      afb_pkg::IdxW'(26): byte_o = fields_i.wtime[31:24];
      afb_pkg::IdxW'(27): byte_o = fields_i.ptime[7:0];
      afb_pkg::IdxW'(28): byte_o = fields_i.ptime[15:8];
      afb_pkg::IdxW'(29): byte_o = fields_i.ptime[23:16];
      afb_pkg::IdxW'(30): byte_o = fields_i.ptime[31:24];
      default:            byte_o = 8'd0;
    endcase
  end

endmodule

// ----- hw/rtl/ack_frame_builder_crc32_core.sv -----
// Acknowledgement frame builder with reflected CRC-32.
//
// Input channel: in_valid_i / in_stall_o carry one acknowledgement request
// per item (echoed sequence, status, two timestamps with valid flags).
// Output channel: out_valid_o / out_stall_i carry one frame byte per item,
// with its offset and a last marker on the final byte.
// Configuration: APB-style port, magic at 0x0, version at 0x4, ack type at
// 0x8. Write only while the block is idle. pready is tied high.
//
// Each request is accepted while idle, then one shared CRC byte unit walks
// the frame (bytes 14..17 read as zero), then the frame is emitted, one
// byte per cycle while the receiver takes them. The CRC walk and the
// byte-serial emit set the pace; no new request is taken until the last
// byte is loaded. The first byte appears once the CRC walk is done.
//
// in_stall_o is high from the accept until the last byte is loaded into the
// output register. A stall on the output holds the current byte and freezes
// the emit counter. Reset clears the registers to zero, the CRC to all ones,
// and leaves the block idle with no output pending.
module ack_frame_builder_crc32_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] echo_sequence_i,
  input  logic        reply_status_i,
  input  logic        weather_valid_i,
  input  logic [31:0] weather_time_i,
  input  logic        position_valid_i,
  input  logic [31:0] position_time_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic [4:0]  byte_index_o,
  output logic        frame_last_o
);

  afb_pkg::state_e           state_q, state_d;
  afb_pkg::cfg_t             cfg_q;
  afb_pkg::fields_t          lat_q;
  afb_pkg::crc_ctrl_t        crc_ctrl;
  logic [afb_pkg::IdxW-1:0]  cnt_q, cnt_d;
  logic [31:0]               crc;
  logic [31:0]               mux_crc;
  logic [7:0]                mux_byte;
  logic                      in_acc;
  logic                      out_free;
  logic                      load_out;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                byte_q;
  logic [4:0]                idx_q;
  logic                      last_q;
  logic [1:0]                reg_sel;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        afb_pkg::RegMagic:   cfg_q.magic    <= pwdata[15:0];
        afb_pkg::RegVersion: cfg_q.version  <= pwdata[7:0];
        afb_pkg::RegAckType: cfg_q.ack_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      afb_pkg::RegMagic:   prdata = {16'd0, cfg_q.magic};
      afb_pkg::RegVersion: prdata = {24'd0, cfg_q.version};
      afb_pkg::RegAckType: prdata = {24'd0, cfg_q.ack_type};
      default:             prdata = 32'd0;
    endcase
  end

  // Latch the request; force each timestamp to zero when its flag is clear.
  assign in_stall_o = (state_q != afb_pkg::StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= '0;
    end else if (in_acc) begin
      lat_q.seq    <= echo_sequence_i;
      lat_q.status <= reply_status_i;
      lat_q.wtime  <= weather_valid_i ? weather_time_i : 32'd0;
      lat_q.ptime  <= position_valid_i ? position_time_i : 32'd0;
    end
  end

  // Shared CRC unit and frame byte selection. The CRC slot reads as zero
  // while the CRC is being accumulated.
  assign mux_crc = (state_q == afb_pkg::StCrc) ? 32'd0 : crc;

  afb_frame_mux u_mux (
    .offset_i (cnt_q),
    .cfg_i    (cfg_q),
    .fields_i (lat_q),
    .crc_i    (mux_crc),
    .byte_o   (mux_byte)
  );

  afb_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: accept, walk the frame through the CRC unit, then emit.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    crc_ctrl.init = 1'b0;
    crc_ctrl.step = 1'b0;
    crc_ctrl.data = mux_byte;
    load_out      = 1'b0;
    case (state_q)
      afb_pkg::StIdle: begin
        if (in_acc) begin
          crc_ctrl.init = 1'b1;
          cnt_d         = '0;
          state_d       = afb_pkg::StCrc;
        end
      end
      afb_pkg::StCrc: begin
        crc_ctrl.step = 1'b1;
        if (cnt_q == afb_pkg::LastIdx) begin
          cnt_d   = '0;
          state_d = afb_pkg::StEmit;
        end else begin
          cnt_d = cnt_q + afb_pkg::IdxW'(1);
        end
      end
      afb_pkg::StEmit: begin
        if (out_free) begin
          load_out = 1'b1;
          if (cnt_q == afb_pkg::LastIdx) begin
            cnt_d   = '0;
            state_d = afb_pkg::StIdle;
          end else begin
            cnt_d = cnt_q + afb_pkg::IdxW'(1);
          end
        end
      end
      default: begin
        state_d = afb_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afb_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register: hold while stalled, drop valid once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      idx_q  <= '0;
      last_q <= 1'b0;
    end else if (load_out) begin
      byte_q <= mux_byte;
      idx_q  <= 5'(cnt_q);
      last_q <= (cnt_q == afb_pkg::LastIdx);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign byte_index_o = idx_q;
  assign frame_last_o = last_q;

endmodule

// ----- tb/ack_frame_builder_crc32_core_test.sv -----
module ack_frame_builder_crc32_core_test;

  // Register index with no register behind it; writes there must be ignored.
  localparam logic [1:0] RegUnused = 2'd3;

  // Abort the run if it gets this far; a clean run needs a small fraction.
  localparam int unsigned CycleLimit = 400000;

  // Idle odds on either side, in percent.
  localparam int unsigned IdlePct = 6;

  // One acknowledgement request as it travels on the input channel.
  typedef struct packed {
    logic [31:0] echo_sequence;
    logic        reply_status;
    logic        weather_valid;
    logic [31:0] weather_time;
    logic        position_valid;
    logic [31:0] position_time;
  } ack_req_t;

  // One emitted frame byte as it travels on the output channel.
  typedef struct packed {
    logic [7:0] data;
    logic [4:0] idx;
    logic       last;
  } frame_byte_t;

  logic        clk_i;
  logic        rst_ni;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] echo_sequence_i;
  logic        reply_status_i;
  logic        weather_valid_i;
  logic [31:0] weather_time_i;
  logic        position_valid_i;
  logic [31:0] position_time_i;

  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  frame_byte_o;
  logic [4:0]  byte_index_o;
  logic        frame_last_o;

  // Requests waiting to be offered, the one on the wires, and the bytes the
  // block still owes us, oldest first.
  ack_req_t      ack_reqs[$];
  ack_req_t      held_req;
  frame_byte_t   expected_bytes[$];

  // Shadow of the configuration registers as the block should hold them.
  afb_pkg::cfg_t shadow_cfg;

  logic        in_took;
  logic        quiet;
  int unsigned fail_count;
  int unsigned cycle_count;

  ack_frame_builder_crc32_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .echo_sequence_i  (echo_sequence_i),
    .reply_status_i   (reply_status_i),
    .weather_valid_i  (weather_valid_i),
    .weather_time_i   (weather_time_i),
    .position_valid_i (position_valid_i),
    .position_time_i  (position_time_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .byte_index_o     (byte_index_o),
    .frame_last_o     (frame_last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Build the frame for one accepted request from the shadow configuration,
  // run the reflected CRC over it with the CRC slot read as zero, patch the
  // CRC in, and queue every byte in offset order.
  task automatic build_ack_frame(input ack_req_t req);
    logic [7:0]  frame [afb_pkg::FrameBytes];
    logic [31:0] wtime;
    logic [31:0] ptime;
    logic [31:0] crc;
    logic [7:0]  crc_in;
    frame_byte_t entry;
    // A clear flag sends the timestamp as zero, whatever the field holds.
    wtime = req.weather_valid ? req.weather_time : 32'h0;
    ptime = req.position_valid ? req.position_time : 32'h0;
    for (int i = 0; i < afb_pkg::FrameBytes; i++) frame[i] = 8'h00;
    frame[0] = shadow_cfg.magic[7:0];
    frame[1] = shadow_cfg.magic[15:8];
    frame[2] = shadow_cfg.version;
    frame[3] = shadow_cfg.ack_type;
    frame[4] = 8'(afb_pkg::FrameBytes);
    frame[5] = 8'(afb_pkg::FrameBytes >> 8);
    for (int k = 0; k < 4; k++) begin
      frame[18 + k] = req.echo_sequence[8*k +: 8];
      frame[23 + k] = wtime[8*k +: 8];
      frame[27 + k] = ptime[8*k +: 8];
    end
    frame[22] = {7'b0, req.reply_status};
    crc = afb_pkg::CrcOnes;
    for (int i = 0; i < afb_pkg::FrameBytes; i++) begin
      crc_in = (i >= afb_pkg::CrcAt && i < afb_pkg::CrcAt + 4) ? 8'h00 : frame[i];
      crc = crc ^ {24'h0, crc_in};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ afb_pkg::CrcPoly) : (crc >> 1);
      end
    end
    crc = crc ^ afb_pkg::CrcOnes;
    for (int k = 0; k < 4; k++) frame[afb_pkg::CrcAt + k] = crc[8*k +: 8];
    for (int i = 0; i < afb_pkg::FrameBytes; i++) begin
      entry.data = frame[i];
      entry.idx  = 5'(i);
      entry.last = (i == afb_pkg::FrameBytes - 1);
      expected_bytes.push_back(entry);
    end
  endtask

  // Write one register: setup cycle, then access cycle; pready is tied high,
  // so the write lands at the edge that closes the access cycle.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      afb_pkg::RegMagic:   shadow_cfg.magic    = value[15:0];
      afb_pkg::RegVersion: shadow_cfg.version  = value[7:0];
      afb_pkg::RegAckType: shadow_cfg.ack_type = value[7:0];
      default: ;
    endcase
  endtask

  task automatic push_req(input logic [31:0] seq, input logic st,
                          input logic wv, input logic [31:0] wt,
                          input logic pv, input logic [31:0] pt);
    ack_req_t req;
    req.echo_sequence  = seq;
    req.reply_status   = st;
    req.weather_valid  = wv;
    req.weather_time   = wt;
    req.position_valid = pv;
    req.position_time  = pt;
    ack_reqs.push_back(req);
  endtask

  // Random word, biased toward the extremes now and then.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Hold off until every queued request has gone in and every byte it owes
  // has come out, then let the block settle back to idle.
  task automatic wait_frames_drained();
    do begin
      @(negedge clk_i);
      #1;
    end while (ack_reqs.size() != 0 || in_valid_i || expected_bytes.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Driver: present the next request once the current one is taken, idle
  // now and then, and throw random stalls at the output side.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_took) begin
        if (ack_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
          held_req = ack_reqs.pop_front();
          echo_sequence_i  <= held_req.echo_sequence;
          reply_status_i   <= held_req.reply_status;
          weather_valid_i  <= held_req.weather_valid;
          weather_time_i   <= held_req.weather_time;
          position_valid_i <= held_req.position_valid;
          position_time_i  <= held_req.position_time;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Monitor: predict on every accepted request, check every accepted byte
  // against the oldest expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        build_ack_frame(held_req);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected frame byte %0h at index %0d", frame_byte_o, byte_index_o);
          fail_count++;
        end else begin
          if (frame_byte_o !== expected_bytes[0].data) begin
            $error("frame_byte: expected %0h, got %0h", expected_bytes[0].data, frame_byte_o);
            fail_count++;
          end
          if (byte_index_o !== expected_bytes[0].idx) begin
            $error("byte_index: expected %0d, got %0d", expected_bytes[0].idx, byte_index_o);
            fail_count++;
          end
          if (frame_last_o !== expected_bytes[0].last) begin
            $error("frame_last: expected %0b, got %0b", expected_bytes[0].last, frame_last_o);
            fail_count++;
          end
          void'(expected_bytes.pop_front());
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ack_frame_builder_crc32_core verification failed");
      $finish;
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = 4'h0;
    pwdata           = 32'h0;
    in_valid_i       = 1'b0;
    echo_sequence_i  = 32'h0;
    reply_status_i   = 1'b0;
    weather_valid_i  = 1'b0;
    weather_time_i   = 32'h0;
    position_valid_i = 1'b0;
    position_time_i  = 32'h0;
    out_stall_i      = 1'b0;
    in_took          = 1'b0;
    quiet            = 1'b0;
    fail_count       = 0;
    cycle_count      = 0;
    shadow_cfg       = '0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, with the registers still at their reset values: extremes of
    // every field, each flag alone, and set-looking timestamps behind a
    // clear flag that must go out as zero.
    push_req(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000);
    push_req(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_req(32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    push_req(32'hAAAA_AAAA, 1'b0, 1'b1, 32'hAAAA_AAAA, 1'b0, 32'h5555_5555);
    push_req(32'h5555_5555, 1'b1, 1'b0, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA);
    push_req(32'h0000_0001, 1'b0, 1'b1, 32'h8000_0000, 1'b1, 32'h8000_0000);
    push_req(32'h8000_0000, 1'b1, 1'b1, 32'h0000_0001, 1'b1, 32'h0000_0001);
    wait_frames_drained();

    // Registers at their maximum, with junk in the unused upper bits, and a
    // write to the empty slot that must leave everything as it was.
    write_reg(afb_pkg::RegMagic,   32'hABCD_FFFF);
    write_reg(afb_pkg::RegVersion, 32'h1234_56FF);
    write_reg(afb_pkg::RegAckType, 32'hFFFF_FFFF);
    write_reg(RegUnused,           32'h0000_0000);
    push_req(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000);
    push_req(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_req(32'h1234_5678, 1'b0, 1'b1, 32'h9ABC_DEF0, 1'b0, 32'h0F0F_0F0F);
    push_req(32'hDEAD_BEEF, 1'b1, 1'b0, 32'hCAFE_F00D, 1'b1, 32'h0000_0000);
    push_req(32'h0000_FFFF, 1'b0, 1'b1, 32'hFFFF_0000, 1'b1, 32'h00FF_FF00);
    wait_frames_drained();

    // Random phases. Each starts from an idle block with a fresh setting;
    // one phase goes back to all zeros, one runs without any idling.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 2) begin
        write_reg(afb_pkg::RegMagic,   32'h0);
        write_reg(afb_pkg::RegVersion, 32'h0);
        write_reg(afb_pkg::RegAckType, 32'h0);
      end else begin
        write_reg(afb_pkg::RegMagic,   $urandom());
        write_reg(afb_pkg::RegVersion, $urandom());
        write_reg(afb_pkg::RegAckType, $urandom());
      end
      if ($urandom_range(0, 3) == 0) write_reg(RegUnused, $urandom());
      quiet = (phase == 5);
      for (int n = 0; n < 40; n++) begin
        push_req(pick_word(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), pick_word(),
                 1'($urandom_range(0, 1)), pick_word());
      end
      wait_frames_drained();
      quiet = 1'b0;
    end

    // Give any stray byte time to show up before the verdict.
    repeat (80) @(negedge clk_i);
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("ack_frame_builder_crc32_core verification clean");
    end else begin
      $display("ack_frame_builder_crc32_core verification failed");
    end
    $finish;
  end

endmodule
